// ----- rtl/core/iad_pkg.sv -----
// shared types and constants for the indexed array insert/delete block
// no dependencies

package iad_pkg;

  localparam int ACT_W  = 3;
  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int CMP_W  = IDX_W + 1;

  localparam int CAPACITY_DEFAULT = 64;

  localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UPDATE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DISPLAY = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic                     load;
    logic [ST_W-1:0]          status;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } out_load_t;

endpackage

// ----- rtl/core/iad_mem.sv -----
// entry storage: one write port, one read port with registered read data
// depends on iad_pkg

module iad_mem #(
  parameter int DEPTH = iad_pkg::CAPACITY_DEFAULT,
  parameter int AW    = $clog2(iad_pkg::CAPACITY_DEFAULT)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [iad_pkg::DATA_W-1:0] wdata,
  input  logic                             re,
  input  logic [AW-1:0]                    raddr,
  output logic signed [iad_pkg::DATA_W-1:0] rdata
);

  logic signed [iad_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/iad_out.sv -----
// output register holding one result transaction until taken
// depends on iad_pkg

module iad_out (
  input  logic                              clk,
  input  logic                              rst,
  input  iad_pkg::out_load_t                ld,
  output logic                              out_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [iad_pkg::ST_W-1:0]          status,
  output logic [iad_pkg::IDX_W-1:0]         out_index,
  output logic signed [iad_pkg::DATA_W-1:0] out_value,
  output logic                              last
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      status    <= ld.status;
      out_index <= ld.index;
      out_value <= ld.value;
      last      <= ld.last;
    end
  end

endmodule

// ----- rtl/core/iad_seq.sv -----
// sequencer: checks each action, walks the shared index stepper over the
// entry storage for shifts and display, and hands results to the output register
// depends on iad_pkg

module iad_seq #(
  parameter int CAPACITY = iad_pkg::CAPACITY_DEFAULT,
  parameter int AW       = $clog2(iad_pkg::CAPACITY_DEFAULT),
  parameter int CW       = $clog2(iad_pkg::CAPACITY_DEFAULT + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [iad_pkg::ACT_W-1:0]         action,
  input  logic [iad_pkg::IDX_W-1:0]         position,
  input  logic signed [iad_pkg::DATA_W-1:0] item_value,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic signed [iad_pkg::DATA_W-1:0] mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  logic signed [iad_pkg::DATA_W-1:0] mem_rdata,
  input  logic                              out_free,
  output iad_pkg::out_load_t                ld
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SHIFT_RD = 3'd1;
  localparam logic [2:0] S_SHIFT_WR = 3'd2;
  localparam logic [2:0] S_PLACE    = 3'd3;
  localparam logic [2:0] S_RESP     = 3'd4;
  localparam logic [2:0] S_DISP_RD  = 3'd5;
  localparam logic [2:0] S_DISP_WR  = 3'd6;

  localparam logic [iad_pkg::CMP_W-1:0] CAP_CMP = iad_pkg::CMP_W'(CAPACITY);

  logic [2:0]                        state, state_next;
  logic [AW-1:0]                     idx, idx_next;
  logic [AW-1:0]                     stop, stop_next;
  logic                              down, down_next;
  logic [CW-1:0]                     count, count_next;
  logic signed [iad_pkg::DATA_W-1:0] val, val_next;
  logic [iad_pkg::ST_W-1:0]          resp_status, resp_status_next;
  logic [iad_pkg::IDX_W-1:0]         resp_index, resp_index_next;

  logic                       accept;
  logic [AW-1:0]              step_idx;
  logic [iad_pkg::CMP_W-1:0]  pos_cmp;
  logic [iad_pkg::CMP_W-1:0]  n_cmp;
  logic [AW-1:0]              pos_a;
  logic [CW-1:0]              cnt_inc;
  logic [CW-1:0]              cnt_dec;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign step_idx = down ? (idx - AW'(1)) : (idx + AW'(1));
  assign pos_cmp  = {1'b0, position};
  assign n_cmp    = iad_pkg::CMP_W'(count);
  assign pos_a    = position[AW-1:0];
  assign cnt_inc  = count + CW'(1);
  assign cnt_dec  = count - CW'(1);

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    stop_next        = stop;
    down_next        = down;
    count_next       = count;
    val_next         = val;
    resp_status_next = resp_status;
    resp_index_next  = resp_index;
    mem_we           = 1'b0;
    mem_waddr        = idx;
    mem_wdata        = mem_rdata;
    mem_re           = 1'b0;
    mem_raddr        = step_idx;
    ld               = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          val_next         = item_value;
          resp_index_next  = position;
          resp_status_next = iad_pkg::ST_OK;
          case (action)
            iad_pkg::ACT_LOAD: begin
              state_next = S_RESP;
              if (position == '0) begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = item_value;
                count_next = CW'(1);
              end else if (pos_cmp != n_cmp) begin
                resp_status_next = iad_pkg::ST_BAD_INDEX;
              end else if (n_cmp >= CAP_CMP) begin
                resp_status_next = iad_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = pos_a;
                mem_wdata  = item_value;
                count_next = cnt_inc;
              end
            end
            iad_pkg::ACT_INSERT: begin
              state_next = S_RESP;
              if (pos_cmp > n_cmp) begin
                resp_status_next = iad_pkg::ST_BAD_INDEX;
              end else if (n_cmp >= CAP_CMP) begin
                resp_status_next = iad_pkg::ST_FULL;
              end else begin
                count_next = cnt_inc;
                if (pos_cmp == n_cmp) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_a;
                  mem_wdata = item_value;
                end else begin
                  idx_next   = count[AW-1:0];
                  stop_next  = pos_a;
                  down_next  = 1'b1;
                  state_next = S_SHIFT_RD;
                end
              end
            end
            iad_pkg::ACT_DELETE: begin
              state_next = S_RESP;
              if (n_cmp == '0) begin
                resp_status_next = iad_pkg::ST_EMPTY;
              end else if (pos_cmp >= n_cmp) begin
                resp_status_next = iad_pkg::ST_BAD_INDEX;
              end else begin
                count_next = cnt_dec;
                if (pos_cmp != iad_pkg::CMP_W'(cnt_dec)) begin
                  idx_next   = pos_a;
                  stop_next  = cnt_dec[AW-1:0];
                  down_next  = 1'b0;
                  state_next = S_SHIFT_RD;
                end
              end
            end
            iad_pkg::ACT_UPDATE: begin
              state_next = S_RESP;
              if (n_cmp == '0) begin
                resp_status_next = iad_pkg::ST_EMPTY;
              end else if (pos_cmp >= n_cmp) begin
                resp_status_next = iad_pkg::ST_BAD_INDEX;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_a;
                mem_wdata = item_value;
              end
            end
            iad_pkg::ACT_DISPLAY: begin
              if (n_cmp == '0) begin
                resp_status_next = iad_pkg::ST_EMPTY;
                resp_index_next  = '0;
                state_next       = S_RESP;
              end else begin
                idx_next   = '0;
                stop_next  = cnt_dec[AW-1:0];
                down_next  = 1'b0;
                state_next = S_DISP_RD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = step_idx;
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        idx_next  = step_idx;
        if (step_idx == stop) begin
          state_next = down ? S_PLACE : S_RESP;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = stop;
        mem_wdata  = val;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          ld.load    = 1'b1;
          ld.status  = resp_status;
          ld.index   = resp_index;
          ld.value   = '0;
          ld.last    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DISP_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx;
        state_next = S_DISP_WR;
      end
      S_DISP_WR: begin
        if (out_free) begin
          ld.load   = 1'b1;
          ld.status = iad_pkg::ST_OK;
          ld.index  = iad_pkg::IDX_W'(idx);
          ld.value  = mem_rdata;
          ld.last   = (idx == stop);
          if (idx == stop) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = step_idx;
            state_next = S_DISP_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    stop        <= stop_next;
    down        <= down_next;
    val         <= val_next;
    resp_status <= resp_status_next;
    resp_index  <= resp_index_next;
  end

endmodule

// ----- rtl/core/indexed_array_insert_delete_top.sv -----
// top level of the indexed array insert/delete block
// depends on iad_pkg, iad_mem, iad_seq, iad_out

// Keeps a packed ordered array of up to CAPACITY signed 32-bit entries in a
// single-port-write, single-port-read memory with registered read data, plus
// an entry count. One transaction is worked on at a time and in_ready is low
// until its work is done. Load, update, insert at the end of the array and
// every rejected action write, if at all, when accepted and then present the
// result from the response state. Insert at p below the count n shifts
// entries p..n-1 up and delete at p shifts the entries above p down; each
// entry moved needs one memory read and one write through the shared index
// stepper. Display reads the n entries through the same read port, showing
// each before the next read. A stalled output holds the block in its result
// state. The next transaction is accepted while the last result still waits
// in the output register. Entries hold no reset value; only entries below
// the count are ever shown, so no clearing pass runs after reset.

module indexed_array_insert_delete_top #(
  parameter int CAPACITY = iad_pkg::CAPACITY_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [iad_pkg::ACT_W-1:0]         action,
  input  logic [iad_pkg::IDX_W-1:0]         position,
  input  logic signed [iad_pkg::DATA_W-1:0] item_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [iad_pkg::ST_W-1:0]          status,
  output logic [iad_pkg::IDX_W-1:0]         out_index,
  output logic signed [iad_pkg::DATA_W-1:0] out_value,
  output logic                              last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic signed [iad_pkg::DATA_W-1:0] mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  logic signed [iad_pkg::DATA_W-1:0] mem_rdata;
  logic                              out_free;
  iad_pkg::out_load_t                ld;

  iad_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  iad_seq #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .position  (position),
    .item_value(item_value),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .ld        (ld)
  );

  iad_out u_out (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .out_index(out_index),
    .out_value(out_value),
    .last     (last)
  );

endmodule

// ----- rtl/core/iad_checker.sv -----
// port-level checks for the indexed array insert/delete block, bound to the top
// depends on iad_pkg and indexed_array_insert_delete_top

module iad_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [iad_pkg::ST_W-1:0]          status,
  input logic [iad_pkg::IDX_W-1:0]         out_index,
  input logic signed [iad_pkg::DATA_W-1:0] out_value,
  input logic                              last
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index)
      && $stable(status) && $stable(last))
    else $error("result changed while stalled");

  // bad-index and full rejections give one result with zero value
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == iad_pkg::ST_BAD_INDEX || status == iad_pkg::ST_FULL)
      |-> last && out_value == '0)
    else $error("error result not single or value not zero");

  // no new transaction taken in the middle of a display run
  a_disp_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input accepted during display run");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind indexed_array_insert_delete_top iad_checker u_iad_checker (.*);

// ----- tb/sv/testbench.sv -----
// testbench for indexed_array_insert_delete_top: checks each result of load, insert,
// delete, update and display against an in-bench model of the array
// depends on iad_pkg and the rtl of the block

`timescale 1ns / 1ps

module testbench;

  localparam int ARRAY_CAP    = iad_pkg::CAPACITY_DEFAULT;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 45;

  localparam logic [iad_pkg::ACT_W-1:0] ACT_RESERVED_LO = iad_pkg::ACT_DISPLAY + 1'b1;
  localparam logic [iad_pkg::ACT_W-1:0] ACT_RESERVED_HI = '1;

  typedef struct packed {
    logic [iad_pkg::ST_W-1:0]          status;
    logic [iad_pkg::IDX_W-1:0]         index;
    logic signed [iad_pkg::DATA_W-1:0] value;
    logic                              last;
  } array_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [iad_pkg::ACT_W-1:0]         action = iad_pkg::ACT_LOAD;
  logic [iad_pkg::IDX_W-1:0]         position = '0;
  logic signed [iad_pkg::DATA_W-1:0] item_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [iad_pkg::ST_W-1:0]          status;
  logic [iad_pkg::IDX_W-1:0]         out_index;
  logic signed [iad_pkg::DATA_W-1:0] out_value;
  logic                              last;

  logic signed [iad_pkg::DATA_W-1:0] model_mem [ARRAY_CAP];
  int                                model_count = 0;
  array_row_t                        expected_rows [$];
  int                                fail_count = 0;
  int                                quiet_cycles = 0;
  bit                                idle_on = 1'b1;

  indexed_array_insert_delete_top #(
    .CAPACITY(ARRAY_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .position(position),
    .item_value(item_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_index(out_index),
    .out_value(out_value),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hi is the highest legal index, negative when there is none
  function automatic logic [iad_pkg::IDX_W-1:0] pick_position(input int hi);
    if (hi < 0 || $urandom_range(0, 9) == 0) return iad_pkg::IDX_W'($urandom);
    return iad_pkg::IDX_W'($urandom_range(0, hi));
  endfunction

  function automatic void push_row(input logic [iad_pkg::ST_W-1:0] st,
                                   input logic [iad_pkg::IDX_W-1:0] idx,
                                   input logic signed [iad_pkg::DATA_W-1:0] val,
                                   input logic lst);
    array_row_t r;
    r.status = st;
    r.index  = idx;
    r.value  = val;
    r.last   = lst;
    expected_rows.push_back(r);
  endfunction

  // apply one transaction to the array model and queue the rows it produces
  function automatic void apply_array_action(input logic [iad_pkg::ACT_W-1:0] act,
                                             input logic [iad_pkg::IDX_W-1:0] pos,
                                             input logic signed [iad_pkg::DATA_W-1:0] val);
    logic [iad_pkg::ST_W-1:0] st;
    int                       i;
    st = iad_pkg::ST_OK;
    case (act)
      iad_pkg::ACT_LOAD: begin
        if (pos == 0) begin
          model_mem[0] = val;
          model_count  = 1;
        end else if (int'(pos) != model_count) begin
          st = iad_pkg::ST_BAD_INDEX;
        end else if (model_count >= ARRAY_CAP) begin
          st = iad_pkg::ST_FULL;
        end else begin
          model_mem[pos] = val;
          model_count++;
        end
      end
      iad_pkg::ACT_INSERT: begin
        if (int'(pos) > model_count) begin
          st = iad_pkg::ST_BAD_INDEX;
        end else if (model_count >= ARRAY_CAP) begin
          st = iad_pkg::ST_FULL;
        end else begin
          for (i = model_count; i > int'(pos); i--) model_mem[i] = model_mem[i-1];
          model_mem[pos] = val;
          model_count++;
        end
      end
      iad_pkg::ACT_DELETE: begin
        if (model_count == 0) begin
          st = iad_pkg::ST_EMPTY;
        end else if (int'(pos) >= model_count) begin
          st = iad_pkg::ST_BAD_INDEX;
        end else begin
          for (i = int'(pos); i + 1 < model_count; i++) model_mem[i] = model_mem[i+1];
          model_count--;
        end
      end
      iad_pkg::ACT_UPDATE: begin
        if (model_count == 0) begin
          st = iad_pkg::ST_EMPTY;
        end else if (int'(pos) >= model_count) begin
          st = iad_pkg::ST_BAD_INDEX;
        end else begin
          model_mem[pos] = val;
        end
      end
      iad_pkg::ACT_DISPLAY: begin
        if (model_count == 0) begin
          push_row(iad_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < model_count; i++) begin
            push_row(iad_pkg::ST_OK, iad_pkg::IDX_W'(i), model_mem[i],
                     i + 1 == model_count);
          end
        end
        return;
      end
      default: return;
    endcase
    push_row(st, pos, '0, 1'b1);
  endfunction

  // drive one transaction and hold it until accepted; valid stays high on return
  task automatic send_item(input logic [iad_pkg::ACT_W-1:0] act,
                           input logic [iad_pkg::IDX_W-1:0] pos,
                           input logic signed [iad_pkg::DATA_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    position   <= pos;
    item_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_array_action(act, pos, val);
  endtask

  task automatic test_empty_array();
    logic [iad_pkg::ACT_W-1:0] a;
    send_item(iad_pkg::ACT_DISPLAY, '0, '0);
    send_item(iad_pkg::ACT_DELETE, '0, '0);
    send_item(iad_pkg::ACT_UPDATE, '0, 32'sh12345678);
    send_item(iad_pkg::ACT_INSERT, 6'd1, -32'sd1);
    send_item(iad_pkg::ACT_LOAD, 6'd5, 32'sd7);
    for (a = ACT_RESERVED_LO; a != ACT_RESERVED_HI; a++) send_item(a, '1, '1);
    send_item(ACT_RESERVED_HI, '1, '1);
  endtask

  task automatic test_basic_edits();
    send_item(iad_pkg::ACT_LOAD, '0, 32'sh7FFFFFFF);
    send_item(iad_pkg::ACT_LOAD, 6'd1, 32'sh80000000);
    send_item(iad_pkg::ACT_LOAD, 6'd3, 32'sd3);
    send_item(iad_pkg::ACT_INSERT, 6'd2, 32'sd0);
    send_item(iad_pkg::ACT_INSERT, '0, -32'sd1);
    send_item(iad_pkg::ACT_INSERT, 6'd5, 32'sd5);
    send_item(iad_pkg::ACT_UPDATE, 6'd3, 32'sh55555555);
    send_item(iad_pkg::ACT_UPDATE, 6'd4, 32'sd4);
    send_item(iad_pkg::ACT_DISPLAY, '0, '0);
    send_item(iad_pkg::ACT_DELETE, 6'd4, '0);
    send_item(iad_pkg::ACT_DELETE, 6'd1, '0);
    send_item(iad_pkg::ACT_DELETE, '0, '0);
    send_item(iad_pkg::ACT_UPDATE, '1, 32'sd1);
    send_item(iad_pkg::ACT_DELETE, '1, '0);
    send_item(iad_pkg::ACT_DISPLAY, '1, '1);
    send_item(iad_pkg::ACT_LOAD, '0, 32'shAAAAAAAA);
    send_item(iad_pkg::ACT_DISPLAY, '0, '0);
  endtask

  // grow to capacity with loads and inserts, then probe the full array
  task automatic test_fill_to_capacity();
    idle_on = 1'b0;
    send_item(iad_pkg::ACT_LOAD, '0, $urandom);
    while (model_count < ARRAY_CAP) begin
      if (model_count == ARRAY_CAP / 2) idle_on = 1'b1;
      if ($urandom_range(0, 1) == 0 && model_count < (1 << iad_pkg::IDX_W))
        send_item(iad_pkg::ACT_LOAD, iad_pkg::IDX_W'(model_count), $urandom);
      else
        send_item(iad_pkg::ACT_INSERT, iad_pkg::IDX_W'($urandom_range(0, model_count)),
                  $urandom);
    end
    send_item(iad_pkg::ACT_INSERT, iad_pkg::IDX_W'($urandom), $urandom);
    send_item(iad_pkg::ACT_INSERT, '0, $urandom);
    send_item(iad_pkg::ACT_LOAD, '1, $urandom);
    send_item(iad_pkg::ACT_DISPLAY, '0, '0);
    send_item(iad_pkg::ACT_UPDATE, '1, $urandom);
    send_item(iad_pkg::ACT_UPDATE, '0, $urandom);
    send_item(iad_pkg::ACT_DELETE, '1, '0);
    send_item(iad_pkg::ACT_LOAD, '1, $urandom);
    send_item(iad_pkg::ACT_INSERT, '1, $urandom);
    send_item(iad_pkg::ACT_DELETE, '0, '0);
    send_item(iad_pkg::ACT_DISPLAY, '0, '0);
  endtask

  task automatic test_random_mix();
    int sent;
    int r;
    int hi_ins;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
      hi_ins = (model_count < (1 << iad_pkg::IDX_W)) ? model_count
                                                       : (1 << iad_pkg::IDX_W) - 1;
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_item(iad_pkg::ACT_INSERT, pick_position(hi_ins), $urandom);
      end else if (r < 42) begin
        send_item(iad_pkg::ACT_DELETE, pick_position(model_count - 1), '0);
      end else if (r < 57) begin
        send_item(iad_pkg::ACT_UPDATE, pick_position(model_count - 1), $urandom);
      end else if (r < 72) begin
        if ($urandom_range(0, 7) == 0) send_item(iad_pkg::ACT_LOAD, '0, $urandom);
        else send_item(iad_pkg::ACT_LOAD, pick_position(hi_ins), $urandom);
      end else if (r < 88) begin
        send_item(iad_pkg::ACT_DISPLAY, iad_pkg::IDX_W'($urandom), $urandom);
      end else begin
        send_item(iad_pkg::ACT_LOAD
                    | iad_pkg::ACT_W'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI)),
                  iad_pkg::IDX_W'($urandom), $urandom);
        sent--;
      end
      sent++;
    end
  endtask

  initial begin : sink_stall
    int n;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    array_row_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected result: status %0d index %0d value %0d last %0d",
               status, out_index, out_value, last);
        fail_count++;
      end else begin
        want = expected_rows.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (out_index !== want.index) begin
          $error("out_index: expected %0d, got %0d", want.index, out_index);
          fail_count++;
        end
        if (out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_value);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_array();
    test_basic_edits();
    test_fill_to_capacity();
    test_random_mix();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/iad_pkg.sv
rtl/core/iad_mem.sv
rtl/core/iad_out.sv
rtl/core/iad_seq.sv
rtl/core/indexed_array_insert_delete_top.sv
rtl/core/iad_checker.sv
tb/sv/testbench.sv
